@@ sv/kls_pkg.sv @@
// Package for the key-list padding stripper: phase encoding, command struct
// and the fixed widths of the byte stream. No dependencies.
`default_nettype none

package kls_pkg;

    localparam int SIZE_W = 17;
    localparam logic [SIZE_W-1:0] SIZE_MAX = 17'h1FFFF;
    localparam logic [SIZE_W-1:0] ENTRY_CAP = 17'd65536;
    localparam logic [SIZE_W-1:0] HDR_BYTES = 17'd4;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW = 2;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_LEN,
        PH_KEY,
        PH_PAD,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic              keep;
        logic [7:0]        data;
        logic              summary;
        logic [SIZE_W-1:0] size;
        logic              err;
    } cmd_t;

endpackage

`default_nettype wire

@@ sv/kls_front.sv @@
// Front end of the key-list padding stripper: parses each accepted byte and
// emits a command for the back end when the byte is kept or ends the buffer. Depends on kls_pkg.
`default_nettype none

module kls_front #(
    parameter int MAX_BUFFER_BYTES = 65536,
    parameter int MAX_KEY_BYTES = 256
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      accept,
    input  wire logic [7:0]                data_byte,
    input  wire logic [kls_pkg::SIZE_W-1:0] buffer_length,
    input  wire logic [kls_pkg::SIZE_W-1:0] entry_count,
    input  wire logic                      first_byte,
    input  wire logic                      last_byte,
    output kls_pkg::cmd_t                  cmd,
    output logic                           push
);
    import kls_pkg::*;

    localparam logic [SIZE_W-1:0] BLEN_CAP =
        (MAX_BUFFER_BYTES > 131071) ? SIZE_MAX : SIZE_W'(MAX_BUFFER_BYTES);

    phase_t            phase_reg, phase_next;
    logic [1:0]        cnt_reg, cnt_next;
    logic [SIZE_W-1:0] rem_reg, rem_next;
    logic [SIZE_W-1:0] ent_reg, ent_next;
    logic [31:0]       acc_reg, acc_next;
    logic [SIZE_W-1:0] kept_reg, kept_next;
    logic              err_reg, err_next;

    always_comb
    begin
        logic [SIZE_W-1:0] blen;
        logic              keep;
        logic [31:0]       key;
        phase_next = phase_reg;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        ent_next = ent_reg;
        acc_next = acc_reg;
        kept_next = kept_reg;
        err_next = err_reg;
        keep = 1'b0;
        blen = '0;
        key = '0;
        cmd = '0;

        if (first_byte)
        begin
            blen = (buffer_length > BLEN_CAP) ? BLEN_CAP : buffer_length;
            ent_next = (entry_count > ENTRY_CAP) ? ENTRY_CAP : entry_count;
            kept_next = '0;
            err_next = 1'b0;
            cnt_next = '0;
            acc_next = '0;
            if (blen < HDR_BYTES)
            begin
                rem_next = '0;
                err_next = 1'b1;
                phase_next = PH_DONE;
            end
            else
            begin
                rem_next = blen - HDR_BYTES;
                phase_next = PH_HEADER;
            end
        end

        unique case (phase_next)
            PH_HEADER:
            begin
                if (cnt_next == 2'd3)
                begin
                    cnt_next = '0;
                    phase_next = PH_LEN;
                end
                else
                begin
                    cnt_next = cnt_next + 2'd1;
                end
            end
            PH_LEN:
            begin
                if (cnt_next == 2'd0 && (ent_next == '0 || rem_next == '0))
                begin
                    phase_next = PH_DONE;
                end
                else if (cnt_next == 2'd0 && rem_next < HDR_BYTES)
                begin
                    err_next = 1'b1;
                    phase_next = PH_DONE;
                end
                else
                begin
                    if (cnt_next == 2'd0)
                    begin
                        ent_next = ent_next - 1'b1;
                        acc_next = '0;
                    end
                    key = acc_next | (32'(data_byte) << {cnt_next, 3'b000});
                    acc_next = key;
                    rem_next = rem_next - 1'b1;
                    keep = 1'b1;
                    if (cnt_next == 2'd3)
                    begin
                        if (key > 32'(rem_next) || key >= 32'(MAX_KEY_BYTES))
                        begin
                            err_next = 1'b1;
                            phase_next = PH_DONE;
                            cnt_next = '0;
                        end
                        else if (key == '0)
                        begin
                            cnt_next = '0;
                        end
                        else
                        begin
                            cnt_next = 2'd0 - key[1:0];
                            phase_next = PH_KEY;
                        end
                    end
                    else
                    begin
                        cnt_next = cnt_next + 2'd1;
                    end
                end
            end
            PH_KEY:
            begin
                keep = 1'b1;
                if (rem_next != '0)
                begin
                    rem_next = rem_next - 1'b1;
                end
                if (acc_next != '0)
                begin
                    acc_next = acc_next - 1'b1;
                end
                if (acc_next == '0)
                begin
                    phase_next = (cnt_next == 2'd0) ? PH_LEN : PH_PAD;
                end
            end
            PH_PAD:
            begin
                if (rem_next != '0)
                begin
                    rem_next = rem_next - 1'b1;
                end
                if (cnt_next != 2'd0)
                begin
                    cnt_next = cnt_next - 2'd1;
                end
                if (cnt_next == 2'd0 || rem_next == '0)
                begin
                    cnt_next = '0;
                    phase_next = PH_LEN;
                end
            end
            default:
            begin
            end
        endcase

        if (keep && kept_next != SIZE_MAX)
        begin
            kept_next = kept_next + 1'b1;
        end

        cmd.keep = keep;
        cmd.data = data_byte;
        cmd.summary = last_byte;
        cmd.size = kept_next;
        cmd.err = err_next;

        if (last_byte)
        begin
            phase_next = PH_DONE;
            kept_next = '0;
            err_next = 1'b0;
        end
    end

    assign push = accept && (cmd.keep || cmd.summary);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            cnt_reg <= '0;
            rem_reg <= '0;
            ent_reg <= '0;
            acc_reg <= '0;
            kept_reg <= '0;
            err_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            cnt_reg <= cnt_next;
            rem_reg <= rem_next;
            ent_reg <= ent_next;
            acc_reg <= acc_next;
            kept_reg <= kept_next;
            err_reg <= err_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/kls_queue.sv @@
// Short command queue between the front and back ends of the key-list
// padding stripper. Depends on kls_pkg.
`default_nettype none

module kls_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire kls_pkg::cmd_t wr_cmd,
    output logic               full,
    input  wire logic          pop,
    output logic               not_empty,
    output kls_pkg::cmd_t      rd_cmd
);
    import kls_pkg::*;

    cmd_t            mem [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg;
    logic [Q_AW-1:0] rd_ptr_reg;
    logic [Q_AW:0]   count_reg;
    logic            do_pop;

    assign full = (count_reg == (Q_AW+1)'(Q_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_pop = pop && not_empty;
    assign rd_cmd = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/kls_back.sv @@
// Back end of the key-list padding stripper: turns each queued command into
// a kept-byte transfer and/or a summary transfer. Depends on kls_pkg.
`default_nettype none

module kls_back (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       q_valid,
    input  wire kls_pkg::cmd_t              q_cmd,
    output logic                            pop,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic                            item_kind,
    output logic [7:0]                      out_byte,
    output logic [kls_pkg::SIZE_W-1:0]      out_size,
    output logic                            status,
    output logic                            final_item
);
    import kls_pkg::*;

    cmd_t cur_reg;
    logic keep_pend_reg;
    logic sum_pend_reg;
    logic moving;
    logic free_next;

    assign out_valid = keep_pend_reg || sum_pend_reg;
    assign moving = out_valid && out_ready;
    assign free_next = !out_valid || (moving && !(keep_pend_reg && sum_pend_reg));
    assign pop = free_next && q_valid;

    assign item_kind = !keep_pend_reg;
    assign out_byte = keep_pend_reg ? cur_reg.data : 8'd0;
    assign out_size = keep_pend_reg ? '0 : cur_reg.size;
    assign status = keep_pend_reg ? 1'b0 : cur_reg.err;
    assign final_item = !keep_pend_reg;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= q_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_pend_reg <= 1'b0;
            sum_pend_reg <= 1'b0;
        end
        else if (pop)
        begin
            keep_pend_reg <= q_cmd.keep;
            sum_pend_reg <= q_cmd.summary;
        end
        else if (moving)
        begin
            if (keep_pend_reg)
            begin
                keep_pend_reg <= 1'b0;
            end
            else
            begin
                sum_pend_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/key_list_padding_stripper.sv @@
// Key-list padding stripper: takes one buffer byte per cycle (one transfer per
// cycle while the four-entry command queue has room). A kept byte or summary
// passes through the command queue and the back end's output register before
// it leaves; a byte that yields both sends the kept byte, then the summary.
// Reset empties the queue and puts the parser in its header phase.
`default_nettype none

module key_list_padding_stripper #(
    parameter int MAX_BUFFER_BYTES = 65536,
    parameter int MAX_KEY_BYTES = 256
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [7:0]                 data_byte,
    input  wire logic [kls_pkg::SIZE_W-1:0] buffer_length,
    input  wire logic [kls_pkg::SIZE_W-1:0] entry_count,
    input  wire logic                       first_byte,
    input  wire logic                       last_byte,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic                            item_kind,
    output logic [7:0]                      out_byte,
    output logic [kls_pkg::SIZE_W-1:0]      out_size,
    output logic                            status,
    output logic                            final_item
);
    import kls_pkg::*;

    cmd_t front_cmd;
    cmd_t head_cmd;
    logic push;
    logic pop;
    logic q_full;
    logic q_valid;

    assign in_ready = !q_full;

    kls_front #(
        .MAX_BUFFER_BYTES(MAX_BUFFER_BYTES),
        .MAX_KEY_BYTES(MAX_KEY_BYTES)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .accept(in_valid && in_ready),
        .data_byte(data_byte),
        .buffer_length(buffer_length),
        .entry_count(entry_count),
        .first_byte(first_byte),
        .last_byte(last_byte),
        .cmd(front_cmd),
        .push(push)
    );

    kls_queue u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .wr_cmd(front_cmd),
        .full(q_full),
        .pop(pop),
        .not_empty(q_valid),
        .rd_cmd(head_cmd)
    );

    kls_back u_back (
        .clk(clk),
        .rst_n(rst_n),
        .q_valid(q_valid),
        .q_cmd(head_cmd),
        .pop(pop),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .item_kind(item_kind),
        .out_byte(out_byte),
        .out_size(out_size),
        .status(status),
        .final_item(final_item)
    );

endmodule

`default_nettype wire

@@ bench/key_list_padding_stripper_test.sv @@
// Self-checking testbench for key_list_padding_stripper: drives buffer bytes through the
// valid/ready input, predicts kept bytes and end-of-buffer summaries, and checks each output.
// Depends on kls_pkg and the key_list_padding_stripper module.

module key_list_padding_stripper_test;

    import kls_pkg::*;

    localparam int BUF_CAP = 65536;
    localparam int KEY_LIMIT = 256;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES = 200;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TARGET_ITEMS = 1150;

    typedef logic [7:0] byte_q_t[$];

    typedef struct packed {
        logic              opens;
        logic              closes;
        logic [7:0]        data;
        logic [SIZE_W-1:0] blen;
        logic [SIZE_W-1:0] ecnt;
    } buf_byte_t;

    typedef struct packed {
        logic              kind;
        logic [7:0]        data;
        logic [SIZE_W-1:0] size;
        logic              err;
        logic              fin;
    } strip_result_t;

    class stripped_stream_board;
        strip_result_t stripped_q[$];
        int failures = 0;
        phase_t ph;
        int unsigned fbc;
        int unsigned remaining;
        int unsigned entries;
        int unsigned acc;
        int unsigned kept;
        bit err_flag;

        function new();
            ph = PH_HEADER;
            fbc = 0;
            remaining = 0;
            entries = 0;
            acc = 0;
            kept = 0;
            err_flag = 0;
        endfunction

        function int pending();
            return stripped_q.size();
        endfunction

        // Advances the parser by one byte; returns 1 when the byte is passed on.
        function bit strip_byte(logic [7:0] b);
            case (ph)
                PH_HEADER:
                begin
                    fbc++;
                    if (fbc >= HDR_BYTES)
                    begin
                        fbc = 0;
                        ph = PH_LEN;
                    end
                    return 1'b0;
                end
                PH_LEN:
                begin
                    if (fbc == 0)
                    begin
                        if (entries == 0 || remaining == 0)
                        begin
                            ph = PH_DONE;
                            return 1'b0;
                        end
                        if (remaining < 4)
                        begin
                            err_flag = 1'b1;
                            ph = PH_DONE;
                            return 1'b0;
                        end
                        entries--;
                        acc = 0;
                    end
                    acc |= 32'(b) << (8 * (fbc & 3));
                    remaining--;
                    fbc++;
                    if (fbc >= 4)
                    begin
                        if (acc > remaining || acc >= KEY_LIMIT)
                        begin
                            err_flag = 1'b1;
                            ph = PH_DONE;
                        end
                        else
                        begin
                            fbc = (4 - (acc & 3)) & 3;
                            if (acc == 0)
                                fbc = 0;
                            else
                                ph = PH_KEY;
                        end
                    end
                    return 1'b1;
                end
                PH_KEY:
                begin
                    if (remaining > 0)
                        remaining--;
                    if (acc > 0)
                        acc--;
                    if (acc == 0)
                        ph = (fbc == 0) ? PH_LEN : PH_PAD;
                    return 1'b1;
                end
                PH_PAD:
                begin
                    if (remaining > 0)
                        remaining--;
                    if (fbc > 0)
                        fbc--;
                    if (fbc == 0 || remaining == 0)
                    begin
                        fbc = 0;
                        ph = PH_LEN;
                    end
                    return 1'b0;
                end
                default:
                    return 1'b0;
            endcase
        endfunction

        function void note_transfer(buf_byte_t it);
            int unsigned blen;
            if (it.opens)
            begin
                blen = (it.blen > BUF_CAP) ? BUF_CAP : it.blen;
                entries = (it.ecnt > ENTRY_CAP) ? ENTRY_CAP : it.ecnt;
                kept = 0;
                err_flag = 1'b0;
                fbc = 0;
                acc = 0;
                if (blen < HDR_BYTES)
                begin
                    remaining = 0;
                    err_flag = 1'b1;
                    ph = PH_DONE;
                end
                else
                begin
                    remaining = blen - HDR_BYTES;
                    ph = PH_HEADER;
                end
            end
            if (strip_byte(it.data))
            begin
                if (kept < SIZE_MAX)
                    kept++;
                stripped_q.push_back('{1'b0, it.data, '0, 1'b0, 1'b0});
            end
            if (it.closes)
            begin
                stripped_q.push_back('{1'b1, 8'h00, SIZE_W'(kept), err_flag, 1'b1});
                ph = PH_DONE;
                kept = 0;
                err_flag = 1'b0;
            end
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", field, want, got);
                failures++;
            end
        endfunction

        function void check_transfer(logic kind, logic [7:0] data, logic [SIZE_W-1:0] size,
                                     logic err, logic fin);
            strip_result_t want;
            if (stripped_q.size() == 0)
            begin
                $error("output transfer with nothing expected: kind %0d byte %0d size %0d",
                       kind, data, size);
                failures++;
                return;
            end
            want = stripped_q.pop_front();
            compare("item_kind", want.kind, kind);
            compare("out_byte", want.data, data);
            compare("out_size", want.size, size);
            compare("status", want.err, err);
            compare("final_item", want.fin, fin);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [7:0] data_byte = '0;
    logic [SIZE_W-1:0] buffer_length = '0;
    logic [SIZE_W-1:0] entry_count = '0;
    logic first_byte = 1'b0;
    logic last_byte = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic item_kind;
    logic [7:0] out_byte;
    logic [SIZE_W-1:0] out_size;
    logic status;
    logic final_item;

    stripped_stream_board board = new();
    bit quiet = 1'b0;
    bit hold_request = 1'b0;
    int buffer_items = 0;
    int cycle_count = 0;

    key_list_padding_stripper dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .data_byte(data_byte),
        .buffer_length(buffer_length),
        .entry_count(entry_count),
        .first_byte(first_byte),
        .last_byte(last_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .item_kind(item_kind),
        .out_byte(out_byte),
        .out_size(out_size),
        .status(status),
        .final_item(final_item)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_transfer(item_kind, out_byte, out_size, status, final_item);
    end

    initial
    begin : receiver
        int hold_left = 0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= quiet || ($urandom_range(99) >= 6);
            @(posedge clk);
        end
    end

    task automatic send_item(buf_byte_t it);
        while (!quiet && $urandom_range(99) < 6)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= it.data;
        buffer_length <= it.blen;
        entry_count <= it.ecnt;
        first_byte <= it.opens;
        last_byte <= it.closes;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_transfer(it);
    endtask

    task automatic send_buffer(byte_q_t img, int unsigned blen, int unsigned ecnt,
                               bit mark_last);
        buf_byte_t it;
        foreach (img[i])
        begin
            it.data = img[i];
            it.opens = (i == 0);
            it.closes = mark_last && (i == img.size() - 1);
            it.blen = it.opens ? SIZE_W'(blen) : SIZE_W'($urandom);
            it.ecnt = it.opens ? SIZE_W'(ecnt) : SIZE_W'($urandom);
            send_item(it);
            buffer_items++;
        end
    endtask

    // Bytes with no first-byte flag; the parser drops them unless they follow a buffer that was left open.
    task automatic send_loose(int count, bit mark_last);
        buf_byte_t it;
        for (int i = 0; i < count; i++)
        begin
            it.data = 8'($urandom);
            it.blen = SIZE_W'($urandom);
            it.ecnt = SIZE_W'($urandom);
            it.opens = 1'b0;
            it.closes = mark_last && (i == count - 1);
            send_item(it);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (board.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic byte_q_t make_image(int entries);
        byte_q_t img;
        int klen;
        repeat (4) img.push_back(8'($urandom));
        repeat (entries)
        begin
            klen = ($urandom_range(24) == 0) ? $urandom_range(255, 13) : $urandom_range(12, 0);
            for (int i = 0; i < 4; i++)
                img.push_back(8'(klen >> (8 * i)));
            repeat (klen) img.push_back(8'($urandom));
            repeat ((4 - klen % 4) % 4) img.push_back(8'($urandom));
        end
        return img;
    endfunction

    initial
    begin : stimulus
        byte_q_t img;
        int unsigned blen;
        int unsigned ecnt;
        int entries;
        int pick;
        int round;
        round = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Bytes before any first byte are dropped and summarize as empty.
        send_loose(1, 1'b1);
        // One-byte buffer shorter than the header.
        send_buffer('{8'h00}, 0, 1, 1'b1);
        // Saturated length and count; a 256-byte key length is rejected.
        send_buffer('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h01, 8'h00, 8'h00},
                    17'h1FFFF, 17'h1FFFF, 1'b1);
        // Padding runs past the declared length, then trailing bytes are dropped.
        send_buffer('{8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h5A,
                      8'h00, 8'hFF}, 9, 5, 1'b1);
        // Length word truncated by the declared length.
        send_buffer('{8'h11, 8'h22, 8'h33, 8'h44, 8'h55}, 6, 1, 1'b1);
        // Key longer than the bytes that remain.
        send_buffer('{8'h00, 8'h00, 8'h00, 8'h00, 8'h05, 8'h00, 8'h00, 8'h00}, 9, 1, 1'b1);
        wait_drained();

        while (buffer_items < TARGET_ITEMS)
        begin
            round++;
            if (round == 6)
                hold_request = 1'b1;
            if (round == 20)
                wait_drained();
            quiet = (round >= 30 && round < 45);
            pick = $urandom_range(99);
            entries = $urandom_range(4, 0);
            img = make_image(entries);
            if (pick < 65)
            begin
                blen = img.size();
                ecnt = entries;
                case ($urandom_range(9))
                    0: blen += $urandom_range(8, 1);
                    1: blen = (blen > 6) ? blen - $urandom_range(6, 1) : blen;
                    2: ecnt = $urandom_range(entries, 0);
                    3: ecnt = $urandom_range(131071, 0);
                    4: repeat ($urandom_range(6, 1)) img.push_back(8'($urandom));
                    default: ;
                endcase
                send_buffer(img, blen, ecnt, 1'b1);
            end
            else if (pick < 82)
            begin
                blen = $urandom_range(img.size() + 4, 0);
                ecnt = $urandom_range(entries + 1, 0);
                if (img.size() > 4 && $urandom_range(1) == 1)
                    img[$urandom_range(img.size() - 1, 4)] = 8'($urandom);
                else
                    img = img[0:$urandom_range(img.size() - 1, 0)];
                send_buffer(img, blen, ecnt, $urandom_range(7) != 0);
            end
            else if (pick < 92)
                send_loose($urandom_range(5, 1), $urandom_range(3) == 0);
            else
            begin
                img.delete();
                repeat ($urandom_range(12, 1)) img.push_back(8'($urandom));
                send_buffer(img, $urandom_range(131071, 0), $urandom_range(131071, 0), 1'b1);
            end
        end
        quiet = 1'b0;

        wait_drained();
        if (board.failures == 0 && board.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
